>>> src/cctc_pkg.sv
// ---------------------------------------------------------------------------
// cctc_pkg: shared types for the CAT command tuner control block
// Config indexes, input modes, reply kinds, controller/datapath command and status groups, reply lengths.
// ---------------------------------------------------------------------------
package cctc_pkg;

  // Configuration register indexes.
  localparam logic CfgFreqMin = 1'b0;
  localparam logic CfgFreqMax = 1'b1;

  // Input item modes.
  localparam logic [2:0] ModeByte = 3'd0;
  localparam logic [2:0] ModeUp   = 3'd1;
  localparam logic [2:0] ModeDown = 3'd2;
  localparam logic [2:0] ModeTx   = 3'd3;
  localparam logic [2:0] ModeStep = 3'd4;
  localparam logic [2:0] ModeEnd  = 3'd5;

  typedef enum logic [3:0] {
    RK_NONE,
    RK_TXQ,
    RK_FAQ,
    RK_AIQ,
    RK_ID,
    RK_MD,
    RK_SH,
    RK_NA,
    RK_IF,
    RK_STQ
  } reply_e;

  // Number of binary bits converted by the double-dabble unit.
  localparam int unsigned FreqW = 24;
  localparam int unsigned ConvCntW = $clog2(FreqW);

  typedef struct packed {
    logic take;
    logic conv_init;
    logic conv_step;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic need_conv;
    logic conv_last;
    logic last;
  } stat_t;

  function automatic logic [4:0] reply_len(reply_e kind);
    logic [4:0] n;
    case (kind)
      RK_TXQ:  n = 5'd4;
      RK_FAQ:  n = 5'd12;
      RK_AIQ:  n = 5'd4;
      RK_ID:   n = 5'd7;
      RK_MD:   n = 5'd5;
      RK_SH:   n = 5'd7;
      RK_NA:   n = 5'd5;
      RK_IF:   n = 5'd28;
      RK_STQ:  n = 5'd4;
      default: n = 5'd1;
    endcase
    return n;
  endfunction

endpackage

>>> src/cctc_ctrl.sv
// ---------------------------------------------------------------------------
// cctc_ctrl: sequencing controller
// Takes one item, runs the decimal conversion when the reply needs it, then
// hands out the reply bytes one transfer at a time.
// ---------------------------------------------------------------------------
module cctc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cctc_pkg::stat_t stat_i,
  output cctc_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CONV,
    ST_SEND
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_SEND);

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.need_conv) begin
          cmd_o.conv_init = 1'b1;
          state_d         = ST_CONV;
        end else begin
          state_d = ST_SEND;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (stat_i.conv_last) state_d = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          if (stat_i.last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/cctc_datapath.sv
// ---------------------------------------------------------------------------
// cctc_datapath: command text tracking, tuner state and reply formatting
// Parses the command text as it arrives, applies set commands and button
// events, converts the frequency to BCD and selects each reply byte.
// ---------------------------------------------------------------------------
module cctc_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [23:0]     cfg_data_i,
  input  logic [2:0]      mode_i,
  input  logic [7:0]      rx_byte_i,
  input  cctc_pkg::cmd_t  cmd_i,
  output cctc_pkg::stat_t stat_o,
  output logic [7:0]      resp_byte_o,
  output logic            has_byte_o,
  output logic            last_o,
  output logic [23:0]     frequency_hz_o,
  output logic            tx_enable_o,
  output logic [1:0]      step_index_o
);

  localparam logic [4:0]   StoreMax = 5'd31;

  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChD = 8'h44;
  localparam logic [7:0] ChF = 8'h46;
  localparam logic [7:0] ChH = 8'h48;
  localparam logic [7:0] ChI = 8'h49;
  localparam logic [7:0] ChM = 8'h4D;
  localparam logic [7:0] ChN = 8'h4E;
  localparam logic [7:0] ChS = 8'h53;
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [7:0] ChX = 8'h58;

  localparam logic [8*7-1:0]  StrId  = "ID0650;";
  localparam logic [8*5-1:0]  StrMd  = "MD0C;";
  localparam logic [8*7-1:0]  StrSh  = "SH0000;";
  localparam logic [8*5-1:0]  StrNa  = "NA00;";
  localparam logic [8*5-1:0]  StrIfA = "IF001";
  localparam logic [8*14-1:0] StrIfB = "+000000C00000;";

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIG,
    PH_STOP,
    PH_REJ
  } phase_e;

  logic [23:0] freq_min_q, freq_max_q;
  logic [23:0] freq_q;
  logic [1:0]  step_q;
  logic        tx_q, ai_q, st_q;
  logic [4:0]  cnt_q, len_q;
  logic        zero_q;
  logic [7:0]  a_q, b_q, c_q;
  phase_e      phase_q;
  logic [31:0] val_q;
  cctc_pkg::reply_e kind_q;
  logic [4:0]  k_q;
  logic [35:0] bcd_q;
  logic [23:0] bin_q;
  logic [cctc_pkg::ConvCntW-1:0] conv_cnt_q;

  function automatic logic [23:0] step_amount(logic [1:0] s);
    logic [23:0] r;
    case (s)
      2'd0:    r = 24'd1000000;
      2'd1:    r = 24'd100000;
      2'd2:    r = 24'd10000;
      default: r = 24'd1000;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] ch);
    return (ch >= ChZero) && (ch <= ChNine);
  endfunction

  function automatic logic [7:0] dec_char(logic [35:0] bcd, logic [4:0] j);
    logic [3:0] pos;
    pos = 4'd8 - j[3:0];
    return {4'h3, bcd[{pos, 2'b00} +: 4]};
  endfunction

  // Text bookkeeping: a nonzero byte joins the text when the store has room and no
  // zero byte came before it.
  logic        is_byte, is_semi, appends, in_text;
  logic [23:0] step_w;
  logic [24:0] up_sum;
  logic [7:0]  ch;
  logic [35:0] acc;
  logic [31:0] acc_sat;
  logic        val_ok;
  cctc_pkg::reply_e kind_d;

  assign is_byte = (mode_i == cctc_pkg::ModeByte);
  assign is_semi = is_byte && (rx_byte_i == ChSemi);
  assign appends = is_byte && !is_semi && (cnt_q < StoreMax);
  assign in_text = appends && !zero_q && (rx_byte_i != 8'h00);
  assign step_w  = step_amount(step_q);
  assign up_sum  = {1'b0, freq_q} + {1'b0, step_w};
  assign ch      = rx_byte_i;
  assign acc     = ({4'h0, val_q} << 3) + ({4'h0, val_q} << 1) +
                   {32'h0, ch[3:0] - 4'h0};
  assign acc_sat = (acc[35:32] != 4'h0) ? 32'hFFFF_FFFF : acc[31:0];
  assign val_ok  = (val_q >= {8'h00, freq_min_q}) && (val_q <= {8'h00, freq_max_q}) &&
                   (phase_q != PH_REJ);

  always_comb begin
    kind_d = cctc_pkg::RK_NONE;
    if (is_semi && (len_q >= 5'd2)) begin
      if (a_q == ChT && b_q == ChX && c_q == 8'h00) kind_d = cctc_pkg::RK_TXQ;
      else if (a_q == ChF && b_q == ChA && c_q == 8'h00) kind_d = cctc_pkg::RK_FAQ;
      else if (a_q == ChA && b_q == ChI && c_q == 8'h00) kind_d = cctc_pkg::RK_AIQ;
      else if (a_q == ChI && b_q == ChD) kind_d = cctc_pkg::RK_ID;
      else if (a_q == ChM && b_q == ChD && c_q == ChZero) kind_d = cctc_pkg::RK_MD;
      else if (a_q == ChS && b_q == ChH) kind_d = cctc_pkg::RK_SH;
      else if (a_q == ChN && b_q == ChA) kind_d = cctc_pkg::RK_NA;
      else if (a_q == ChI && b_q == ChF) kind_d = cctc_pkg::RK_IF;
      else if (a_q == ChS && b_q == ChT && c_q == 8'h00) kind_d = cctc_pkg::RK_STQ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_min_q <= 24'd8000000;
      freq_max_q <= 24'd16000000;
      freq_q     <= 24'd10000000;
      step_q     <= 2'd0;
      tx_q       <= 1'b0;
      ai_q       <= 1'b0;
      st_q       <= 1'b0;
      cnt_q      <= '0;
      len_q      <= '0;
      zero_q     <= 1'b0;
      c_q        <= '0;
      phase_q    <= PH_SKIP;
      val_q      <= '0;
      kind_q     <= cctc_pkg::RK_NONE;
      k_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == cctc_pkg::CfgFreqMin) freq_min_q <= cfg_data_i;
        else freq_max_q <= cfg_data_i;
      end
      if (cmd_i.advance) k_q <= k_q + 5'd1;
      if (cmd_i.take) begin
        kind_q <= kind_d;
        k_q    <= '0;
        case (mode_i)
          cctc_pkg::ModeByte: begin
            if (is_semi) begin
              if (len_q >= 5'd2) begin
                if (a_q == ChT && b_q == ChX) begin
                  if (c_q == ChZero) tx_q <= 1'b0;
                  else if (c_q == ChOne) tx_q <= 1'b1;
                end else if (a_q == ChF && b_q == ChA) begin
                  if (c_q != 8'h00 && val_ok) freq_q <= val_q[23:0];
                end else if (a_q == ChA && b_q == ChI) begin
                  if (c_q == ChZero) ai_q <= 1'b0;
                  else if (c_q == ChOne) ai_q <= 1'b1;
                end else if (a_q == ChS && b_q == ChT) begin
                  if (c_q == ChZero) st_q <= 1'b0;
                  else if (c_q == ChOne) st_q <= 1'b1;
                end
              end
              cnt_q   <= '0;
              len_q   <= '0;
              zero_q  <= 1'b0;
              c_q     <= '0;
              phase_q <= PH_SKIP;
              val_q   <= '0;
            end else if (appends) begin
              cnt_q <= cnt_q + 5'd1;
              if (!zero_q && rx_byte_i == 8'h00) zero_q <= 1'b1;
              if (in_text) begin
                len_q <= len_q + 5'd1;
                if (len_q == 5'd2) c_q <= rx_byte_i;
                if (len_q >= 5'd2) begin
                  case (phase_q)
                    PH_SKIP: begin
                      if (ch == ChSpace || (ch >= 8'd9 && ch <= 8'd13)) begin
                        phase_q <= PH_SKIP;
                      end else if (ch == ChMinus) phase_q <= PH_REJ;
                      else if (ch == ChPlus) phase_q <= PH_DIG;
                      else if (is_digit(ch)) begin
                        val_q   <= acc_sat;
                        phase_q <= PH_DIG;
                      end else phase_q <= PH_STOP;
                    end
                    PH_DIG: begin
                      if (is_digit(ch)) val_q <= acc_sat;
                      else phase_q <= PH_STOP;
                    end
                    default: phase_q <= phase_q;
                  endcase
                end
              end
            end
          end
          cctc_pkg::ModeUp: begin
            if (up_sum <= {1'b0, freq_max_q}) freq_q <= up_sum[23:0];
          end
          cctc_pkg::ModeDown: begin
            if (freq_q >= step_w && (freq_q - step_w) >= freq_min_q) begin
              freq_q <= freq_q - step_w;
            end
          end
          cctc_pkg::ModeTx:   tx_q   <= ~tx_q;
          cctc_pkg::ModeStep: step_q <= step_q + 2'd1;
          cctc_pkg::ModeEnd: begin
            cnt_q   <= '0;
            len_q   <= '0;
            zero_q  <= 1'b0;
            c_q     <= '0;
            phase_q <= PH_SKIP;
            val_q   <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // The first two text bytes are held where the decoder sees them directly.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_text) begin
      if (len_q == 5'd0) a_q <= rx_byte_i;
      if (len_q == 5'd1) b_q <= rx_byte_i;
    end
  end

  // Double-dabble conversion, one bit per cycle.
  logic [35:0] bcd_adj;
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_cnt_q <= '0;
    end else if (cmd_i.conv_init) begin
      conv_cnt_q <= '0;
    end else if (cmd_i.conv_step) begin
      conv_cnt_q <= conv_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.conv_init) begin
      bcd_q <= '0;
      bin_q <= freq_q;
    end else if (cmd_i.conv_step) begin
      bcd_q <= {bcd_adj[34:0], bin_q[23]};
      bin_q <= {bin_q[22:0], 1'b0};
    end
  end

  always_comb begin
    logic [4:0] j;
    j = k_q;
    resp_byte_o = 8'h00;
    case (kind_q)
      cctc_pkg::RK_TXQ, cctc_pkg::RK_AIQ, cctc_pkg::RK_STQ: begin
        case (k_q)
          5'd0: resp_byte_o = (kind_q == cctc_pkg::RK_TXQ) ? ChT :
                              (kind_q == cctc_pkg::RK_AIQ) ? ChA : ChS;
          5'd1: resp_byte_o = (kind_q == cctc_pkg::RK_TXQ) ? ChX :
                              (kind_q == cctc_pkg::RK_AIQ) ? ChI : ChT;
          5'd2: resp_byte_o = {7'h18, (kind_q == cctc_pkg::RK_TXQ) ? tx_q :
                              (kind_q == cctc_pkg::RK_AIQ) ? ai_q : st_q};
          default: resp_byte_o = ChSemi;
        endcase
      end
      cctc_pkg::RK_FAQ: begin
        if (k_q == 5'd0) resp_byte_o = ChF;
        else if (k_q == 5'd1) resp_byte_o = ChA;
        else if (k_q == 5'd11) resp_byte_o = ChSemi;
        else resp_byte_o = dec_char(bcd_q, j - 5'd2);
      end
      cctc_pkg::RK_ID: resp_byte_o = StrId[8*(3'd6 - k_q[2:0]) +: 8];
      cctc_pkg::RK_SH: resp_byte_o = StrSh[8*(3'd6 - k_q[2:0]) +: 8];
      cctc_pkg::RK_MD: resp_byte_o = StrMd[8*(3'd4 - k_q[2:0]) +: 8];
      cctc_pkg::RK_NA: resp_byte_o = StrNa[8*(3'd4 - k_q[2:0]) +: 8];
      cctc_pkg::RK_IF: begin
        if (k_q < 5'd5) resp_byte_o = StrIfA[8*(3'd4 - k_q[2:0]) +: 8];
        else if (k_q < 5'd14) resp_byte_o = dec_char(bcd_q, j - 5'd5);
        else resp_byte_o = StrIfB[8*(4'd13 - 4'(j - 5'd14)) +: 8];
      end
      default: resp_byte_o = 8'h00;
    endcase
  end

  assign has_byte_o     = (kind_q != cctc_pkg::RK_NONE);
  assign last_o         = stat_o.last;
  assign frequency_hz_o = freq_q;
  assign tx_enable_o    = tx_q;
  assign step_index_o   = step_q;

  assign stat_o.need_conv = (kind_q == cctc_pkg::RK_FAQ) || (kind_q == cctc_pkg::RK_IF);
  assign stat_o.conv_last = (conv_cnt_q == cctc_pkg::ConvCntW'(cctc_pkg::FreqW - 1));
  assign stat_o.last      = (k_q == cctc_pkg::reply_len(kind_q) - 5'd1);

endmodule

>>> src/cat_command_tuner_control.sv
// ---------------------------------------------------------------------------
// cat_command_tuner_control: CAT command parser and tuner front panel logic
// Input items are UART bytes or button events; each item produces one or more
// result transfers carrying reply bytes and the current tuner state.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid_i/in_ready_o) takes one item at a time.
// Each item gives at least one result transfer on the output channel
// (out_valid_o/out_ready_i); an item without a reply gives a single transfer
// with has_byte_o low and last_o high, a reply gives one transfer per byte
// with last_o on the final one. Results follow the input transfer through
// a check state, and for replies that print the frequency (FA and IF
// queries) through a conversion state as well, in which a double-dabble
// unit converts one binary bit of the 24-bit frequency per cycle. Reply
// bytes then go out one per cycle while the receiver is ready; a reply
// has at most 28 bytes.
// A new item is taken only after the last result transfer of the previous
// one. When the receiver stalls, the current result holds and input waits.
// Reset restores the limits to 8 MHz and 16 MHz, the frequency to 10 MHz,
// clears TX, the flags, the step select and any partial command text.
// Limit registers are written through cfg_we_i/cfg_index_i/cfg_data_i.
// ---------------------------------------------------------------------------
module cat_command_tuner_control (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  resp_byte_o,
  output logic        has_byte_o,
  output logic        last_o,
  output logic [23:0] frequency_hz_o,
  output logic        tx_enable_o,
  output logic [1:0]  step_index_o
);

  cctc_pkg::cmd_t  cmd;
  cctc_pkg::stat_t stat;

  cctc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cctc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (mode_i),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .resp_byte_o    (resp_byte_o),
    .has_byte_o     (has_byte_o),
    .last_o         (last_o),
    .frequency_hz_o (frequency_hz_o),
    .tx_enable_o    (tx_enable_o),
    .step_index_o   (step_index_o)
  );

endmodule

>>> dv/testbench.sv
// ---------------------------------------------------------------------------
// CAT command tuner control testbench
// Sends UART command bytes and button events, predicts every reply byte and
// the tuner state in a scoreboard, and checks each output transfer against it.
// ---------------------------------------------------------------------------
module testbench;

  typedef enum logic [2:0] {
    M_BYTE = cctc_pkg::ModeByte,
    M_UP   = cctc_pkg::ModeUp,
    M_DOWN = cctc_pkg::ModeDown,
    M_TX   = cctc_pkg::ModeTx,
    M_STEP = cctc_pkg::ModeStep,
    M_END  = cctc_pkg::ModeEnd,
    M_RSV6 = 3'd6,
    M_RSV7 = 3'd7
  } mode_e;

  localparam int unsigned StoreMax = 31;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned ItemTarget = 450;
  localparam int unsigned PhaseLen = 36;

  typedef struct packed {
    logic [7:0]  resp_byte;
    logic        has_byte;
    logic        last;
    logic [23:0] freq;
    logic        tx;
    logic [1:0]  step;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  mode_i = '0;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  resp_byte_o;
  logic        has_byte_o;
  logic        last_o;
  logic [23:0] frequency_hz_o;
  logic        tx_enable_o;
  logic [1:0]  step_index_o;

  cat_command_tuner_control i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Tuner state as the scoreboard sees it.
  logic [7:0]  cmd_text [StoreMax];
  int unsigned text_cnt;
  logic [31:0] tuned_hz;
  logic [1:0]  step_sel;
  logic        tx_on, ai_on, st_on;
  logic [31:0] lim_lo, lim_hi;
  logic [7:0]  reply_q[$];
  result_t     expected_q[$];

  int unsigned err_cnt;
  int unsigned sent_cnt;
  bit          no_idle;
  int unsigned stall_left;
  int unsigned idle_cycles;

  function automatic logic [31:0] step_hz(logic [1:0] sel);
    case (sel)
      2'd0: return 32'd1000000;
      2'd1: return 32'd100000;
      2'd2: return 32'd10000;
      default: return 32'd1000;
    endcase
  endfunction

  function automatic string fmt_result(result_t r);
    return $sformatf("byte %h has %b last %b freq %0d tx %b step %0d",
                     r.resp_byte, r.has_byte, r.last, r.freq, r.tx, r.step);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) reply_q.push_back(s[i]);
  endfunction

  function automatic void put_digits(logic [31:0] v);
    logic [7:0] d [9];
    for (int i = 8; i >= 0; i--) begin
      d[i] = 8'h30 + 8'(v % 10);
      v = v / 10;
    end
    for (int i = 0; i < 9; i++) reply_q.push_back(d[i]);
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void parse_freq(int unsigned len);
    int unsigned i;
    logic [63:0] v;
    logic [7:0]  c;
    i = 2;
    v = 0;
    while (i < len && is_blank(cmd_text[i])) i++;
    c = (i < len) ? cmd_text[i] : 8'h00;
    if (c == "-") return;
    if (c == "+") i++;
    while (i < len && cmd_text[i] >= "0" && cmd_text[i] <= "9") begin
      v = v * 10 + (cmd_text[i] - "0");
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      i++;
    end
    if (v >= lim_lo && v <= lim_hi) tuned_hz = v[31:0];
  endfunction

  function automatic void decode_text();
    int unsigned len;
    logic [7:0]  a, b, c;
    len = 0;
    while (len < text_cnt && cmd_text[len] != 8'h00) len++;
    if (len < 2) return;
    a = cmd_text[0];
    b = cmd_text[1];
    c = (len > 2) ? cmd_text[2] : 8'h00;
    if (a == "T" && b == "X") begin
      if (c == 8'h00) begin
        put_str("TX"); reply_q.push_back(8'h30 + tx_on); put_str(";");
      end else if (c == "0" || c == "1") begin
        tx_on = c[0];
      end
    end else if (a == "F" && b == "A") begin
      if (c == 8'h00) begin
        put_str("FA"); put_digits(tuned_hz); put_str(";");
      end else begin
        parse_freq(len);
      end
    end else if (a == "A" && b == "I") begin
      if (c == 8'h00) begin
        put_str("AI"); reply_q.push_back(8'h30 + ai_on); put_str(";");
      end else if (c == "0" || c == "1") begin
        ai_on = c[0];
      end
    end else if (a == "I" && b == "D") begin
      put_str("ID0650;");
    end else if (a == "M" && b == "D") begin
      if (c == "0") put_str("MD0C;");
    end else if (a == "S" && b == "H") begin
      put_str("SH0000;");
    end else if (a == "N" && b == "A") begin
      put_str("NA00;");
    end else if (a == "I" && b == "F") begin
      put_str("IF001"); put_digits(tuned_hz); put_str("+000000C00000;");
    end else if (a == "S" && b == "T") begin
      if (c == 8'h00) begin
        put_str("ST"); reply_q.push_back(8'h30 + st_on); put_str(";");
      end else if (c == "0" || c == "1") begin
        st_on = c[0];
      end
    end
  endfunction

  // Updates the tuner state for one item and queues the results it causes.
  function automatic void predict_item(mode_e m, logic [7:0] b);
    logic [31:0] st;
    int unsigned n;
    result_t     r;
    st = step_hz(step_sel);
    reply_q.delete();
    case (m)
      M_BYTE: begin
        if (b == ";") begin
          decode_text();
          text_cnt = 0;
        end else if (text_cnt < StoreMax) begin
          cmd_text[text_cnt] = b;
          text_cnt++;
        end
      end
      M_UP:   if (tuned_hz + st <= lim_hi) tuned_hz += st;
      M_DOWN: if (tuned_hz >= st && tuned_hz - st >= lim_lo) tuned_hz -= st;
      M_TX:   tx_on = ~tx_on;
      M_STEP: step_sel = step_sel + 2'd1;
      M_END:  text_cnt = 0;
      default: ;
    endcase
    n = (reply_q.size() != 0) ? reply_q.size() : 1;
    for (int k = 0; k < n; k++) begin
      r.resp_byte = (reply_q.size() != 0) ? reply_q[k] : 8'h00;
      r.has_byte  = reply_q.size() != 0;
      r.last      = (k + 1 == n);
      r.freq      = tuned_hz[23:0];
      r.tx        = tx_on;
      r.step      = step_sel;
      expected_q.push_back(r);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_item(mode_e m, logic [7:0] b);
    int unsigned g;
    in_valid_i <= 1'b1;
    mode_i     <= m;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(m, b);
    sent_cnt++;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(M_BYTE, s[i]);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limits(logic [23:0] lo, logic [23:0] hi);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= cctc_pkg::CfgFreqMin;
    cfg_data_i  <= lo;
    @(posedge clk_i);
    cfg_index_i <= cctc_pkg::CfgFreqMax;
    cfg_data_i  <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lim_lo = lo;
    lim_hi = hi;
  endtask

  // Output side: random backpressure, checking and the watchdog.
  always @(posedge clk_i) begin
    result_t got, want;
    logic    rdy;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{resp_byte_o, has_byte_o, last_o, frequency_hz_o, tx_enable_o, step_index_o};
      if (expected_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual %s", $time,
                 fmt_result(got));
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          $display("%0t: mismatch expected %s, actual %s", $time,
                   fmt_result(want), fmt_result(got));
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
      if (!no_idle && $urandom_range(0, 99) < 20)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                 : $urandom_range(1, 3);
    end
    out_ready_i <= rdy;
  end

  task automatic test_buttons();
    send_item(M_UP, 8'h00);
    send_item(M_DOWN, 8'hFF);
    repeat (4) send_item(M_STEP, 8'h00);
    send_item(M_TX, 8'h00);
    send_item(M_TX, 8'h00);
    send_item(M_RSV6, 8'h3B);
    send_item(M_RSV7, 8'h3B);
    repeat (6) send_item(M_UP, 8'h00);
  endtask

  task automatic test_queries();
    send_text("FA;IF;ID;MD0;MD1;SH;NA;TX;AI1;AI;ST1;ST;TX2;X;;");
    // Zero byte cuts the text short, so this is an ID query.
    send_text("ID"); send_item(M_BYTE, 8'h00); send_text("ZZ;");
    send_text("TX1;TX;TX0;");
    send_text("FA12"); send_item(M_END, 8'h00); send_text("3;");
  endtask

  task automatic test_freq_set();
    send_text("FA \t+9000000;FA;FA-9000000;FA++9000000;FA;FA99999999999999;FA;");
    send_text("FA;");
    for (int i = 0; i < 40; i++) send_item(M_BYTE, "1");
    send_text(";FA;");
  endtask

  task automatic test_limits();
    write_limits(24'd0, 24'hFFFFFF);
    send_text("FA500;FA;");
    send_item(M_DOWN, 8'h00);
    send_text("FA0;FA;FA;FA16777215;FA16777216;");
    send_item(M_UP, 8'h00);
    send_text("IF;");
    write_limits(24'd12345678, 24'd12345678);
    send_text("FA12345678;FA12345677;IF;");
    send_item(M_UP, 8'h00);
    send_item(M_DOWN, 8'h00);
  endtask

  task automatic random_command();
    int unsigned p;
    string s;
    p = $urandom_range(0, 99);
    if (p < 30) begin
      case ($urandom_range(0, 9))
        0: s = "TX;";
        1: s = $sformatf("TX%0d;", $urandom_range(0, 2));
        2: s = "FA;";
        3: s = $sformatf("AI%0d;", $urandom_range(0, 2));
        4: s = "AI;";
        5: s = $sformatf("ST%0d;", $urandom_range(0, 2));
        6: s = "ST;";
        7: s = ($urandom_range(0, 1) != 0) ? "ID;" : "MD0;";
        8: s = ($urandom_range(0, 1) != 0) ? "SH;" : "NA;";
        default: s = "IF;";
      endcase
      send_text(s);
    end else if (p < 45) begin
      case ($urandom_range(0, 3))
        0: s = "";
        1: s = " ";
        2: s = "+";
        default: s = "-";
      endcase
      if ($urandom_range(0, 3) != 0)
        s = $sformatf("FA%s%0d;", s, $urandom_range(lim_lo, lim_hi));
      else
        s = $sformatf("FA%s%0d;", s, $urandom());
      send_text(s);
    end else if (p < 75) begin
      send_item(mode_e'($urandom_range(1, 7)), 8'($urandom()));
    end else if (p < 92) begin
      repeat ($urandom_range(1, 5)) send_item(M_BYTE, 8'($urandom()));
    end else begin
      // May run past the store depth before the terminator arrives.
      repeat ($urandom_range(28, 36)) send_item(M_BYTE, 8'($urandom_range(32, 126)));
      send_item(M_BYTE, ";");
    end
  endtask

  task automatic test_random();
    int unsigned phase;
    int unsigned base;
    phase = 0;
    base = sent_cnt;
    while (sent_cnt < ItemTarget) begin
      if ((sent_cnt - base) / PhaseLen != phase) begin
        phase = (sent_cnt - base) / PhaseLen;
        no_idle = (phase == 2);
        case (phase)
          1: write_limits(24'd0, 24'hFFFFFF);
          3: write_limits(24'd9000000, 24'd11000000);
          4: write_limits(24'd8000000, 24'd16000000);
          default: wait_drained();
        endcase
      end
      random_command();
    end
    no_idle = 0;
  endtask

  initial begin
    text_cnt = 0;
    tuned_hz = 32'd10000000;
    step_sel = 2'd0;
    tx_on = 1'b0;
    ai_on = 1'b0;
    st_on = 1'b0;
    lim_lo = 32'd8000000;
    lim_hi = 32'd16000000;
    err_cnt = 0;
    sent_cnt = 0;
    no_idle = 0;
    stall_left = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_buttons();
    test_queries();
    test_freq_set();
    test_limits();
    write_limits(24'd8000000, 24'd16000000);
    test_random();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
